/* rtl/bfau_pkg.sv */
`timescale 1ns / 1ps
package bfau_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    localparam logic [15:0] QNAN     = 16'h7FC0;
    localparam logic [15:0] INF_BITS = 16'h7F80;
    localparam logic [15:0] SIGN_BIT = 16'h8000;
    localparam int          STAGES   = 6;

    // Per-stage payload. Fields are reused by the three datapaths.
    typedef struct packed {
        logic               done;
        logic [15:0]        res;
        cmd_t               op;
        logic               norm;
        logic               sr;
        logic               sb;
        logic signed [10:0] er;
        logic [7:0]         ma;
        logic [7:0]         mb;
        logic [15:0]        prod;
        logic [7:0]         rem;
    } pipe_t;

    typedef struct packed {
        logic [7:0] rem;
        logic [3:0] q;
    } div_nib_t;

    function automatic logic [15:0] pack_val(input logic s, input logic signed [10:0] e,
                                             input logic [7:0] m);
        logic [15:0] r;
        if (e > 11'sd254)
            r = {s, INF_BITS[14:0]};
        else if (e < 11'sd1)
            r = {s, 15'd0};
        else
            r = {s, e[7:0], m[6:0]};
        return r;
    endfunction

    // Four restoring division steps
    function automatic div_nib_t div_nib(input logic [7:0] rem, input logic [3:0] nbits,
                                         input logic [7:0] d);
        div_nib_t   o;
        logic [8:0] r;
        logic [7:0] cur;
        cur = rem;
        for (int i = 3; i >= 0; i--)
        begin
            r = {cur, nbits[i]};
            if (r >= {1'b0, d})
            begin
                r        = r - {1'b0, d};
                o.q[i]   = 1'b1;
            end
            else
            begin
                o.q[i] = 1'b0;
            end
            cur = r[7:0];
        end
        o.rem = cur;
        return o;
    endfunction

endpackage

/* rtl/bfloat16_arith_unit_core.sv */
`timescale 1ns / 1ps
// Truncating bfloat16 add/subtract/multiply/divide. Six register stages:
// one request is taken per cycle when the result side does not stall;
// the divider's four 4-bit restoring stages set the depth. A stall on the
// result side holds the whole pipe.
module bfloat16_arith_unit_core
    import bfau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  command,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [15:0] result_value
);

    pipe_t              p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    pipe_t              p1_next, p2_next, p3_next, p4_next, p5_next, p6_next;
    logic [STAGES-1:0]  v_reg;
    logic [STAGES-1:0]  v_next;
    logic               en;

    assign en           = !v_reg[STAGES-1] || res_ready;
    assign cmd_ready    = en;
    assign res_valid    = v_reg[STAGES-1];
    assign result_value = p6_reg.res;

    function automatic pipe_t stage1(input logic [1:0] c, input logic [15:0] a,
                                     input logic [15:0] b);
        pipe_t              p;
        logic [15:0]        b2;
        logic [7:0]         ea, eb;
        logic signed [8:0]  d;
        logic signed [10:0] xa, xb;
        p    = '0;
        p.op = cmd_t'(c);
        b2   = (p.op == CMD_SUB) ? (b ^ SIGN_BIT) : b;
        ea   = a[14:7];
        eb   = b[14:7];
        if ((ea == 8'hFF && a[6:0] != 7'd0) || (eb == 8'hFF && b[6:0] != 7'd0))
        begin
            p.done = 1'b1;
            p.res  = QNAN;
        end
        else
        begin
            case (p.op)
                CMD_ADD, CMD_SUB:
                begin
                    if (ea == 8'd0)
                    begin
                        p.done = 1'b1;
                        p.res  = b2;
                    end
                    else if (eb == 8'd0)
                    begin
                        p.done = 1'b1;
                        p.res  = a;
                    end
                    else
                    begin
                        d    = $signed({1'b0, ea}) - $signed({1'b0, eb});
                        p.sr = a[15];
                        p.sb = b2[15];
                        p.ma = {(ea != 8'hFF), a[6:0]};
                        p.mb = {(eb != 8'hFF), b[6:0]};
                        if (d > 9'sd8)
                        begin
                            p.done = 1'b1;
                            p.res  = a;
                        end
                        else if (d < -9'sd8)
                        begin
                            p.done = 1'b1;
                            p.res  = b2;
                        end
                        else if (d > 9'sd0)
                        begin
                            p.mb = p.mb >> d[3:0];
                            p.er = $signed({3'b0, ea});
                        end
                        else
                        begin
                            p.ma = p.ma >> (-d);
                            p.er = $signed({3'b0, eb});
                        end
                    end
                end
                CMD_MUL:
                begin
                    p.sr = a[15] ^ b[15];
                    xa   = (ea != 8'd0) ? ($signed({3'b0, ea}) - 11'sd127) : -11'sd126;
                    xb   = (eb != 8'd0) ? ($signed({3'b0, eb}) - 11'sd127) : -11'sd126;
                    p.er = xa + xb;
                    p.ma = {(ea != 8'd0), a[6:0]};
                    p.mb = {(eb != 8'd0), b[6:0]};
                end
                default:
                begin
                    p.sr = a[15] ^ b[15];
                    p.ma = {(ea != 8'd0 && ea != 8'hFF), a[6:0]};
                    p.mb = {(eb != 8'd0 && eb != 8'hFF), b[6:0]};
                    p.er = $signed({3'b0, ea}) - $signed({3'b0, eb}) + 11'sd127;
                    if (a[14:0] == 15'd0)
                    begin
                        p.done = 1'b1;
                        p.res  = (b[14:0] == 15'd0) ? QNAN : {p.sr, 15'd0};
                    end
                    else if (b[14:0] == 15'd0)
                    begin
                        p.done = 1'b1;
                        p.res  = {p.sr, INF_BITS[14:0]};
                    end
                    else if (p.ma == 8'd0 || p.mb == 8'd0)
                    begin
                        p.done = 1'b1;
                        p.res  = {p.sr, 15'd0};
                    end
                end
            endcase
        end
        return p;
    endfunction

    function automatic pipe_t stage2(input pipe_t pi);
        pipe_t      p;
        logic [8:0] sum;
        div_nib_t   n;
        p = pi;
        if (!p.done)
        begin
            case (p.op)
                CMD_ADD, CMD_SUB:
                begin
                    if (p.sr == p.sb)
                    begin
                        sum    = {1'b0, p.ma} + {1'b0, p.mb};
                        p.norm = 1'b0;
                        if (sum[8])
                        begin
                            p.ma = sum[8:1];
                            p.er = p.er + 11'sd1;
                        end
                        else
                        begin
                            p.ma = sum[7:0];
                        end
                    end
                    else if (p.ma > p.mb)
                    begin
                        p.norm = 1'b1;
                        p.ma   = p.ma - p.mb;
                    end
                    else if (p.mb > p.ma)
                    begin
                        p.norm = 1'b1;
                        p.sr   = p.sb;
                        p.ma   = p.mb - p.ma;
                    end
                    else
                    begin
                        p.done = 1'b1;
                        p.res  = 16'd0;
                    end
                end
                CMD_MUL:
                begin
                    p.prod = p.ma * p.mb;
                end
                default:
                begin
                    n              = div_nib(8'd0, p.ma[7:4], p.mb);
                    p.rem          = n.rem;
                    p.prod[15:12]  = n.q;
                end
            endcase
        end
        return p;
    endfunction

    function automatic pipe_t stage3(input pipe_t pi);
        pipe_t              p;
        logic [2:0]         lz;
        logic               found;
        logic [7:0]         m;
        logic signed [10:0] e2;
        logic signed [10:0] sh;
        div_nib_t           n;
        p = pi;
        if (!p.done)
        begin
            case (p.op)
                CMD_ADD, CMD_SUB:
                begin
                    lz    = 3'd0;
                    found = 1'b0;
                    for (int i = 7; i >= 0; i--)
                    begin
                        if (!found && p.ma[i])
                        begin
                            lz    = 3'(7 - i);
                            found = 1'b1;
                        end
                    end
                    if (p.norm)
                    begin
                        m  = p.ma << lz;
                        e2 = p.er - $signed({8'd0, lz});
                    end
                    else
                    begin
                        m  = p.ma;
                        e2 = p.er;
                    end
                    p.done = 1'b1;
                    p.res  = pack_val(p.sr, e2, m);
                end
                CMD_MUL:
                begin
                    p.done = 1'b1;
                    if (p.prod == 16'd0)
                    begin
                        p.res = {p.sr, 15'd0};
                    end
                    else
                    begin
                        m  = p.prod[15] ? p.prod[15:8] : p.prod[14:7];
                        e2 = p.er + (p.prod[15] ? 11'sd1 : 11'sd0);
                        if (e2 <= -11'sd126)
                        begin
                            // underflow: shifted subnormal
                            sh    = -11'sd125 - e2;
                            m     = (sh >= 11'sd8) ? 8'd0 : (m >> sh[2:0]);
                            p.res = {p.sr, 8'd0, m[6:0]};
                        end
                        else if (e2 >= 11'sd128)
                        begin
                            p.res = {p.sr, INF_BITS[14:0]};
                        end
                        else
                        begin
                            e2    = e2 + 11'sd127;
                            p.res = {p.sr, e2[7:0], m[6:0]};
                        end
                    end
                end
                default:
                begin
                    n             = div_nib(p.rem, p.ma[3:0], p.mb);
                    p.rem         = n.rem;
                    p.prod[11:8]  = n.q;
                end
            endcase
        end
        return p;
    endfunction

    function automatic pipe_t stage_div(input pipe_t pi, input logic lo);
        pipe_t    p;
        div_nib_t n;
        p = pi;
        if (!p.done && p.op == CMD_DIV)
        begin
            n     = div_nib(p.rem, 4'd0, p.mb);
            p.rem = n.rem;
            if (lo)
                p.prod[3:0] = n.q;
            else
                p.prod[7:4] = n.q;
        end
        return p;
    endfunction

    function automatic pipe_t stage6(input pipe_t pi);
        pipe_t              p;
        logic [3:0]         msb;
        logic [15:0]        t;
        logic signed [10:0] e2;
        p   = pi;
        msb = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (p.prod[i])
                msb = 4'(i);
        end
        if (!p.done)
        begin
            t      = p.prod << (4'd15 - msb);
            e2     = p.er + $signed({7'd0, msb}) - 11'sd7;
            p.done = 1'b1;
            p.res  = pack_val(p.sr, e2, {1'b1, t[14:8]});
        end
        return p;
    endfunction

    always_comb
    begin
        p1_next = stage1(command, operand_a, operand_b);
        p2_next = stage2(p1_reg);
        p3_next = stage3(p2_reg);
        p4_next = stage_div(p3_reg, 1'b0);
        p5_next = stage_div(p4_reg, 1'b1);
        p6_next = stage6(p5_reg);
        v_next  = {v_reg[STAGES-2:0], cmd_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= v_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            p4_reg <= p4_next;
            p5_reg <= p5_next;
            p6_reg <= p6_next;
        end
    end

endmodule

/* rtl/bfau_checker.sv */
`timescale 1ns / 1ps
module bfau_checker
    import bfau_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] result_value
);

    // held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(result_value))
        else $error("result changed under stall");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_ready |-> cmd_ready)
        else $error("request side blocked with result side free");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("request taken while pipe is stalled");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready ##1 res_ready ##1 res_ready ##1 res_ready
        ##1 res_ready ##1 res_ready |=> res_valid)
        else $error("result missing after pipeline latency");

endmodule

bind bfloat16_arith_unit_core bfau_checker u_bfau_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .result_value (result_value)
);
